@@ rtl/core/sst_pkg.sv @@
// Shared types, codes and constants of the sensor slot table.
package sst_pkg;

    // Command codes carried on the input tuser.
    localparam logic [2:0] CMD_LOOKUP    = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_EXPIRE    = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_REPLACE   = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_INVALID   = 2'd3;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int LIMIT_W            = 22;

    // One slot entry, node key in the lowest byte.
    typedef struct packed {
        logic [7:0]  flags;
        logic [31:0] stamp;
        logic [7:0]  sensor;
        logic [7:0]  type_key;
        logic [7:0]  node;
    } entry_t;

    // Memory port controls issued by the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
        logic clr_all;
    } store_req_t;

    // Scan start controls.
    typedef struct packed {
        logic start;
        logic expire;
        logic want_oldest;
    } scan_ctl_t;

endpackage

@@ rtl/core/sst_store.sv @@
// Slot memory with per-entry valid bits and a registered read port.
module sst_store import sst_pkg::*; #(
    parameter int SLOTS = 64,
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  store_req_t       req,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_entry,
    output entry_t           rd_entry
);

    entry_t            mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    entry_t            rdata_reg;
    logic              rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (req.rd_en) begin
            rdata_reg  <= mem[rd_addr];
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    // A slot that was never written since the last clear reads as all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clr_all) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end else if (req.clr_en) begin
            valid_reg[wr_addr] <= 1'b0;
        end
    end

    assign rd_entry = rvalid_reg ? rdata_reg : '0;

endmodule

@@ rtl/core/sst_scan.sv @@
// Per-slot evaluation during a scan: key match, replacement choice and expiry.
module sst_scan import sst_pkg::*; #(
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  scan_ctl_t        ctl,
    input  logic [7:0]       node_i,
    input  logic [7:0]       type_i,
    input  logic [7:0]       sensor_i,
    input  logic [31:0]      now_i,
    input  logic [15:0]      age_i,
    input  logic             rd_vld,
    input  logic [IDX_W-1:0] rd_idx,
    input  entry_t           rd_entry,
    output logic             expire_hit,
    output logic [IDX_W-1:0] res_idx,
    output logic [1:0]       res_status
);

    logic               expire_reg;
    logic               want_reg;
    logic [7:0]         node_reg;
    logic [7:0]         type_reg;
    logic [7:0]         sensor_reg;
    logic [31:0]        now_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               blank_reg;
    logic [IDX_W-1:0]   blank_idx_reg;
    logic [IDX_W-1:0]   cand_idx_reg;
    logic [31:0]        cand_t_reg;

    logic match;
    logic blank;
    logic older;
    logic [31:0] elapsed;

    always_comb begin
        match   = (rd_entry.node == node_reg) && (rd_entry.type_key == type_reg) &&
                  (rd_entry.sensor == sensor_reg);
        blank   = (rd_entry.node == 8'd0) && (rd_entry.type_key == 8'd0) &&
                  (rd_entry.sensor == 8'd0);
        older   = (cand_t_reg == 32'd0) ||
                  ((rd_entry.stamp != 32'd0) && (rd_entry.stamp < cand_t_reg));
        elapsed = now_reg - rd_entry.stamp;
        expire_hit = rd_vld && expire_reg && (rd_entry.sensor != 8'd0) &&
                     (rd_entry.stamp != 32'd0) && (elapsed > {10'd0, limit_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expire_reg <= 1'b0;
            want_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            blank_reg  <= 1'b0;
        end else if (ctl.start) begin
            expire_reg <= ctl.expire;
            want_reg   <= ctl.want_oldest;
            hit_reg    <= 1'b0;
            blank_reg  <= 1'b0;
        end else if (rd_vld && !expire_reg) begin
            if (!hit_reg && match) begin
                hit_reg <= 1'b1;
            end
            if (!blank_reg && blank) begin
                blank_reg <= 1'b1;
            end
        end
    end

    // Keys, limit and the running candidate need no reset.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            node_reg     <= node_i;
            type_reg     <= type_i;
            sensor_reg   <= sensor_i;
            now_reg      <= now_i;
            limit_reg    <= LIMIT_W'(age_i) * LIMIT_W'(SECONDS_PER_MINUTE);
            cand_idx_reg <= '0;
            cand_t_reg   <= '0;
        end else if (rd_vld && !expire_reg) begin
            if (!hit_reg && match) begin
                hit_idx_reg <= rd_idx;
            end
            if (!blank_reg) begin
                if (blank) begin
                    blank_idx_reg <= rd_idx;
                end else if (older) begin
                    cand_idx_reg <= rd_idx;
                    cand_t_reg   <= rd_entry.stamp;
                end
            end
        end
    end

    always_comb begin
        res_idx    = '0;
        res_status = STAT_DONE;
        if (!expire_reg) begin
            if (hit_reg) begin
                res_idx = hit_idx_reg;
            end else if (want_reg) begin
                res_idx    = blank_reg ? blank_idx_reg : cand_idx_reg;
                res_status = STAT_REPLACE;
            end else begin
                res_status = STAT_NOT_FOUND;
            end
        end
    end

endmodule

@@ rtl/core/sensor_slot_table_core.sv @@
// Sensor slot table: keyed slot store with lookup, replacement choice and expiry.
// Lookups with a nonzero sensor key and expire walk the whole table before the result is
// registered; the single read port visits one slot per cycle. Write, clear, clear-all,
// zero-key lookups and undefined commands go to the result register without a scan. A new
// word is taken only when idle, once the last result is loaded into the output register.
// Synchronous active-low reset empties every slot at once through the valid bits
// and leaves the block idle with no result pending.
module sensor_slot_table_core import sst_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: node_id[7:0], type_key[15:8], sensor_key[23:16],
    // want_oldest[24], slot[30:25], logged_time[62:31], flag_bits[70:63],
    // now_seconds[102:71], age_minutes[118:103], zero pad[119].
    input  logic [119:0] s_tdata,
    // s_tuser: command[2:0].
    input  logic [2:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: slot_index[5:0], zero pad[7:6].
    output logic [7:0]   m_tdata,
    // m_tuser: status[1:0].
    output logic [1:0]   m_tuser
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    // Unpacked input word.
    logic [7:0]  in_node;
    logic [7:0]  in_type;
    logic [7:0]  in_sensor;
    logic        in_want;
    logic [5:0]  in_slot;
    logic [31:0] in_ltime;
    logic [7:0]  in_flags;
    logic [31:0] in_now;
    logic [15:0] in_age;

    assign in_node   = s_tdata[7:0];
    assign in_type   = s_tdata[15:8];
    assign in_sensor = s_tdata[23:16];
    assign in_want   = s_tdata[24];
    assign in_slot   = s_tdata[30:25];
    assign in_ltime  = s_tdata[62:31];
    assign in_flags  = s_tdata[70:63];
    assign in_now    = s_tdata[102:71];
    assign in_age    = s_tdata[118:103];

    logic [1:0]       state_reg;
    logic             issue_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             from_scan_reg;
    logic [1:0]       res_status_reg;
    logic             m_tvalid_reg;
    logic [5:0]       m_idx_reg;
    logic [1:0]       m_status_reg;

    logic             accept;
    logic             slot_ok;
    logic             scan_start;
    logic [1:0]       direct_status;
    store_req_t       store_req;
    scan_ctl_t        scan_ctl;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic             expire_hit;
    logic [IDX_W-1:0] scan_idx;
    logic [1:0]       scan_status;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The slot field can name entries beyond a small table.
    assign slot_ok  = 32'(in_slot) < 32'(SLOTS);

    // Lookups with a usable key and expiry walk the whole table.
    assign scan_start = accept && (((s_tuser == CMD_LOOKUP) && (in_sensor != 8'd0)) ||
                                   (s_tuser == CMD_EXPIRE));

    always_comb begin
        unique case (s_tuser)
            CMD_LOOKUP:             direct_status = STAT_INVALID;
            CMD_WRITE, CMD_CLEAR:   direct_status = slot_ok ? STAT_DONE : STAT_INVALID;
            CMD_EXPIRE:             direct_status = STAT_DONE;
            CMD_CLEAR_ALL:          direct_status = STAT_DONE;
            default:                direct_status = STAT_INVALID;
        endcase
    end

    // Writes and single clears happen on acceptance; expiry clears each slot
    // the cycle after it is read, while the next slot is being read.
    always_comb begin
        store_req.rd_en   = (state_reg == S_SCAN) && issue_reg;
        store_req.wr_en   = accept && (s_tuser == CMD_WRITE) && slot_ok;
        store_req.clr_en  = (accept && (s_tuser == CMD_CLEAR) && slot_ok) || expire_hit;
        store_req.clr_all = accept && (s_tuser == CMD_CLEAR_ALL);
        wr_addr           = (state_reg == S_SCAN) ? rd_idx_reg : IDX_W'(in_slot);
        wr_entry.flags    = in_flags;
        wr_entry.stamp    = in_ltime;
        wr_entry.sensor   = in_sensor;
        wr_entry.type_key = in_type;
        wr_entry.node     = in_node;
        scan_ctl.start       = scan_start;
        scan_ctl.expire      = (s_tuser == CMD_EXPIRE);
        scan_ctl.want_oldest = in_want;
    end

    sst_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (store_req),
        .rd_addr  (addr_reg),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    sst_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .node_i     (in_node),
        .type_i     (in_type),
        .sensor_i   (in_sensor),
        .now_i      (in_now),
        .age_i      (in_age),
        .rd_vld     (rd_vld_reg),
        .rd_idx     (rd_idx_reg),
        .rd_entry   (rd_entry),
        .expire_hit (expire_hit),
        .res_idx    (scan_idx),
        .res_status (scan_status)
    );

    // Sequencer: issue one read per cycle during a scan, then hand the result
    // to the output register as soon as that register is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            from_scan_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            rd_vld_reg  <= store_req.rd_en;
            rd_last_reg <= store_req.rd_en && (addr_reg == LAST_IDX);
            // The output register loads a result when it is free or being emptied.
            if ((state_reg == S_RESULT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        from_scan_reg <= scan_start;
                        if (scan_start) begin
                            state_reg <= S_SCAN;
                            issue_reg <= 1'b1;
                            addr_reg  <= '0;
                        end else begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue_reg) begin
                        if (addr_reg == LAST_IDX) begin
                            issue_reg <= 1'b0;
                        end else begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    // The last slot is evaluated at this edge; the scan result
                    // is settled from the next cycle on.
                    if (rd_last_reg) begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= addr_reg;
        if (accept) begin
            res_status_reg <= direct_status;
        end
        if ((state_reg == S_RESULT) && (!m_tvalid_reg || m_tready)) begin
            m_idx_reg    <= from_scan_reg ? 6'(scan_idx) : 6'd0;
            m_status_reg <= from_scan_reg ? scan_status : res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_idx_reg};
    assign m_tuser  = m_status_reg;

endmodule

@@ rtl/core/sst_checker.sv @@
// Port-level checks of the sensor slot table and their binding to the top level.
module sst_checker import sst_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata,
    input logic [1:0]   m_tuser
);

    logic [2:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Words accepted but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == STAT_INVALID) || (m_tuser == STAT_NOT_FOUND))
        |-> (m_tdata[5:0] == 6'd0))
        else $error("slot index not zero on a miss or invalid request");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input taken again right after an acceptance");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg <= 3'd2) && (!m_tvalid || (pending_reg != 3'd0)))
        else $error("results out of step with accepted words");

endmodule

bind sensor_slot_table_core sst_checker u_sst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
